// ===== hdl/mbg_pkg.sv =====
// Shared types, constants and the rounding multiply for the monomial basis generator.
package mbg_pkg;

  localparam int DEG_LIMIT = 5;
  localparam int COORD_WIDTH = 16;
  localparam int CW = COORD_WIDTH;
  localparam int FRAC = CW - 1;
  localparam int DW = $clog2(DEG_LIMIT + 1);
  localparam int TERM_W = 6;
  localparam int NCOORD = 3;
  localparam int CFG_DIMS_W = 2;
  localparam int CFG_DEG_W = 3;
  localparam int CFG_DATA_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam int COORD_X = 0;
  localparam int COORD_Y = 1;
  localparam int COORD_Z = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEG = 1'b1;

  localparam logic [CFG_DIMS_W-1:0] DIMS_NONE = 2'd0;
  localparam logic [CFG_DIMS_W-1:0] DIMS_1 = 2'd1;
  localparam logic [CFG_DIMS_W-1:0] DIMS_2 = 2'd2;
  localparam logic [CFG_DIMS_W-1:0] DIMS_3 = 2'd3;

  localparam logic [CFG_DIMS_W-1:0] DIMS_RESET = DIMS_3;
  localparam logic [CFG_DEG_W-1:0] DEG_RESET = 3'd2;
  localparam logic [CFG_DEG_W-1:0] DEG_LIMIT_CFG = CFG_DEG_W'(DEG_LIMIT);

  typedef logic signed [CW-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {FRAC{1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {FRAC{1'b0}}};

  typedef val_t [NCOORD-1:0] coord_vec_t;
  typedef val_t [DEG_LIMIT-1:0] pw_row_t;
  typedef logic [DEG_LIMIT-1:0] ps_row_t;
  typedef val_t [DEG_LIMIT:0] bank_row_t;
  typedef logic [DEG_LIMIT:0] bank_ps_row_t;

  // one beat travelling down the power chain; pw[c][i] holds a power of coordinate c
  typedef struct packed {
    logic valid;
    coord_vec_t coord;
    pw_row_t [NCOORD-1:0] pw;
    ps_row_t [NCOORD-1:0] ps;
  } pw_beat_t;

  // finished power table of one point; entry e is the e-th power, entry 0 unused
  typedef struct packed {
    bank_row_t [NCOORD-1:0] pw;
    bank_ps_row_t [NCOORD-1:0] ps;
  } bank_t;

  typedef struct packed {
    logic valid;
    logic hx;
    logic hy;
    logic hz;
    val_t vx;
    val_t vy;
    val_t vz;
    logic sx;
    logic sy;
    logic sz;
    logic [TERM_W-1:0] k;
    logic last;
  } term_req_t;

  typedef struct packed {
    val_t val;
    logic sat;
  } rs_t;

  // Q1.F product, round to nearest (ties up), saturate
  function automatic rs_t mul_rs(val_t a, val_t b);
    logic signed [2*CW-1:0] prod;
    logic signed [2*CW:0] sum;
    logic signed [CW+1:0] q;
    rs_t r;
    prod = a * b;
    sum = {prod[2*CW-1], prod} + {{(CW+2){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
    q = sum[2*CW:FRAC];
    if (q > $signed({3'b000, {FRAC{1'b1}}})) begin
      r.val = VAL_MAX;
      r.sat = 1'b1;
    end else if (q < $signed({3'b111, {FRAC{1'b0}}})) begin
      r.val = VAL_MIN;
      r.sat = 1'b1;
    end else begin
      r.val = q[CW-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/mbg_in_if.sv =====
// Point channel: valid/ready handshake carrying one (x, y, z) point per beat.
interface mbg_in_if import mbg_pkg::*; ();
  logic valid;
  logic ready;
  val_t x_coord;
  val_t y_coord;
  val_t z_coord;

  modport source (output valid, output x_coord, output y_coord, output z_coord,
                  input ready);
  modport sink (input valid, input x_coord, input y_coord, input z_coord,
                output ready);
endinterface

// ===== hdl/mbg_out_if.sv =====
// Term channel: valid/ready handshake carrying one monomial per beat.
interface mbg_out_if import mbg_pkg::*; ();
  logic valid;
  logic ready;
  val_t term_value;
  logic [TERM_W-1:0] term_index;
  logic last_term;
  logic saturated;

  modport source (output valid, output term_value, output term_index,
                  output last_term, output saturated, input ready);
  modport sink (input valid, input term_value, input term_index,
                input last_term, input saturated, output ready);
endinterface

// ===== hdl/monomial_basis_generator_top.sv =====
// Each accepted point yields 1 + D terms in 1D, (D+1)(D+2)/2 in 2D and (D+1)(D+2)(D+3)/6 in 3D
// (D = max_degree, capped at 5), up to 56 beats, on the result channel. A point's powers
// come out of a chain of four multiply cells, one power per cycle, into a holding table; the
// next point is taken as soon as that table has been handed to the term sequencer, so its
// powers are built while the previous point is still being emitted and points follow each
// other without gaps when the output is not stalled and a point's terms outlast the next
// point's passage through the chain. The term multiplier pair gives one term per cycle while
// the result channel is ready. From an idle block, a point's first term passes the four cells,
// the holding table, the sequencer, stage 1 and the output register. Configuration is sampled
// when a point starts emitting and should only be written while the block is idle.
module monomial_basis_generator_top import mbg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mbg_in_if.sink                in_ch,
  mbg_out_if.source             out_ch
);

  logic [CFG_DIMS_W-1:0] dims_r, dims_nxt;
  logic [CFG_DEG_W-1:0]  deg_r, deg_nxt;
  logic [CFG_DIMS_W-1:0] dims_eff;
  logic [DW-1:0]         deg_eff;

  pw_beat_t  chain [DEG_LIMIT];
  logic      chain_busy;
  logic      accept;
  logic      pend_v_r, pend_v_nxt;
  bank_t     pend_bank_r, pend_bank_nxt;
  logic      take;
  logic      advance;
  term_req_t req;

  // configuration
  always_comb begin
    dims_nxt = dims_r;
    deg_nxt = deg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIMS: dims_nxt = cfg_data[CFG_DIMS_W-1:0];
        CFG_DEG:  deg_nxt = cfg_data[CFG_DEG_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= DIMS_RESET;
      deg_r <= DEG_RESET;
    end else begin
      dims_r <= dims_nxt;
      deg_r <= deg_nxt;
    end
  end

  assign dims_eff = (dims_r == DIMS_NONE) ? DIMS_1 : dims_r;
  assign deg_eff = (deg_r > DEG_LIMIT_CFG) ? DW'(DEG_LIMIT) : DW'(deg_r);

  // power chain
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    chain[0] = '0;
    chain[0].valid = accept;
    chain[0].coord[COORD_X] = in_ch.x_coord;
    chain[0].coord[COORD_Y] = in_ch.y_coord;
    chain[0].coord[COORD_Z] = in_ch.z_coord;
    for (int c = 0; c < NCOORD; c++) begin
      chain[0].pw[c][DEG_LIMIT-1] = chain[0].coord[c];
    end
  end

  for (genvar g = 0; g < DEG_LIMIT - 1; g++) begin : g_cell
    mbg_power_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .beat_i (chain[g]),
      .beat_o (chain[g+1])
    );
  end

  always_comb begin
    chain_busy = 1'b0;
    for (int i = 1; i < DEG_LIMIT; i++) begin
      chain_busy = chain_busy | chain[i].valid;
    end
  end

  assign in_ch.ready = !pend_v_r && !chain_busy;

  // holding table between the chain and the sequencer
  always_comb begin
    pend_bank_nxt = pend_bank_r;
    if (chain[DEG_LIMIT-1].valid) begin
      for (int c = 0; c < NCOORD; c++) begin
        pend_bank_nxt.pw[c][0] = '0;
        pend_bank_nxt.ps[c][0] = 1'b0;
        for (int e = 1; e <= DEG_LIMIT; e++) begin
          pend_bank_nxt.pw[c][e] = chain[DEG_LIMIT-1].pw[c][e-1];
          pend_bank_nxt.ps[c][e] = chain[DEG_LIMIT-1].ps[c][e-1];
        end
      end
    end
  end

  always_comb begin
    pend_v_nxt = pend_v_r;
    if (chain[DEG_LIMIT-1].valid) begin
      pend_v_nxt = 1'b1;
    end else if (take) begin
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_bank_r <= pend_bank_nxt;
  end

  mbg_term_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .pend_v    (pend_v_r),
    .pend_bank (pend_bank_r),
    .dims_eff  (dims_eff),
    .deg_eff   (deg_eff),
    .advance   (advance),
    .take      (take),
    .req       (req)
  );

  mbg_term_pipe u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

// ===== hdl/mbg_power_cell.sv =====
// One cell of the power chain: raises the newest power by one and shifts the history.
module mbg_power_cell import mbg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  pw_beat_t beat_i,
  output pw_beat_t beat_o
);

  pw_beat_t beat_nxt;
  pw_beat_t data_r;
  logic     valid_r;
  logic     valid_nxt;
  rs_t      rs [NCOORD];

  always_comb begin
    beat_nxt = beat_i;
    for (int c = 0; c < NCOORD; c++) begin
      rs[c] = mul_rs(beat_i.pw[c][DEG_LIMIT-1], beat_i.coord[c]);
      for (int i = 0; i < DEG_LIMIT - 1; i++) begin
        beat_nxt.pw[c][i] = beat_i.pw[c][i+1];
        beat_nxt.ps[c][i] = beat_i.ps[c][i+1];
      end
      beat_nxt.pw[c][DEG_LIMIT-1] = rs[c].val;
      beat_nxt.ps[c][DEG_LIMIT-1] = beat_i.ps[c][DEG_LIMIT-1] | rs[c].sat;
    end
  end

  assign valid_nxt = beat_i.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= beat_nxt;
  end

  always_comb begin
    beat_o = data_r;
    beat_o.valid = valid_r;
  end

endmodule

// ===== hdl/mbg_term_seq.sv =====
// Term sequencer: holds the active power table and walks the exponents in graded order.
module mbg_term_seq import mbg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pend_v,
  input  bank_t                 pend_bank,
  input  logic [CFG_DIMS_W-1:0] dims_eff,
  input  logic [DW-1:0]         deg_eff,
  input  logic                  advance,
  output logic                  take,
  output term_req_t             req
);

  logic                  act_v_r, act_v_nxt;
  bank_t                 bank_r, bank_nxt;
  logic [CFG_DIMS_W-1:0] dims_r, dims_nxt;
  logic [DW-1:0]         deg_r, deg_nxt;
  logic [DW-1:0]         d_r, d_nxt;
  logic [DW-1:0]         l_r, l_nxt;
  logic [DW-1:0]         m_r, m_nxt;
  logic [TERM_W-1:0]     k_r, k_nxt;
  logic [DW-1:0]         n;
  logic                  last;
  logic                  issue;

  assign n = d_r - l_r - m_r;
  assign last = (d_r == deg_r) &&
                ((dims_r == DIMS_1) || ((l_r == '0) && ((dims_r == DIMS_2) || (m_r == '0))));
  assign issue = advance && act_v_r;
  assign take = pend_v && (!act_v_r || (issue && last));

  always_comb begin
    req.valid = act_v_r;
    req.hx = (l_r != '0);
    req.hy = (m_r != '0);
    req.hz = (n != '0);
    req.vx = bank_r.pw[COORD_X][l_r];
    req.vy = bank_r.pw[COORD_Y][m_r];
    req.vz = bank_r.pw[COORD_Z][n];
    req.sx = bank_r.ps[COORD_X][l_r];
    req.sy = bank_r.ps[COORD_Y][m_r];
    req.sz = bank_r.ps[COORD_Z][n];
    req.k = k_r;
    req.last = last;
  end

  always_comb begin
    act_v_nxt = act_v_r;
    bank_nxt = bank_r;
    dims_nxt = dims_r;
    deg_nxt = deg_r;
    d_nxt = d_r;
    l_nxt = l_r;
    m_nxt = m_r;
    k_nxt = k_r;
    if (take) begin
      act_v_nxt = 1'b1;
      bank_nxt = pend_bank;
      dims_nxt = dims_eff;
      deg_nxt = deg_eff;
      d_nxt = '0;
      l_nxt = '0;
      m_nxt = '0;
      k_nxt = '0;
    end else if (issue) begin
      k_nxt = k_r + 1'b1;
      if (last) begin
        act_v_nxt = 1'b0;
      end else begin
        // next degree opens with the pure x power
        d_nxt = d_r + 1'b1;
        l_nxt = d_r + 1'b1;
        m_nxt = '0;
        case (dims_r)
          DIMS_1: begin
          end
          DIMS_2: begin
            if (l_r != '0) begin
              d_nxt = d_r;
              l_nxt = l_r - 1'b1;
              m_nxt = m_r + 1'b1;
            end
          end
          default: begin
            if (m_r != '0) begin
              d_nxt = d_r;
              l_nxt = l_r;
              m_nxt = m_r - 1'b1;
            end else if (l_r != '0) begin
              d_nxt = d_r;
              l_nxt = l_r - 1'b1;
              m_nxt = d_r - l_r + 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_v_r <= 1'b0;
      d_r <= '0;
      l_r <= '0;
      m_r <= '0;
      k_r <= '0;
      dims_r <= DIMS_RESET;
      deg_r <= '0;
    end else begin
      act_v_r <= act_v_nxt;
      d_r <= d_nxt;
      l_r <= l_nxt;
      m_r <= m_nxt;
      k_r <= k_nxt;
      dims_r <= dims_nxt;
      deg_r <= deg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r <= bank_nxt;
  end

endmodule

// ===== hdl/mbg_term_pipe.sv =====
// Term product pipeline: x*y product, then times z, into the output register.
module mbg_term_pipe import mbg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  term_req_t req,
  output logic      advance,
  mbg_out_if.source out_ch
);

  // stage 1
  logic              s1_v_r, s1_v_nxt;
  val_t              s1_a_r, s1_a_nxt;
  logic              s1_as_r, s1_as_nxt;
  logic              s1_ah_r, s1_ah_nxt;
  logic              s1_hz_r;
  val_t              s1_vz_r;
  logic              s1_sz_r;
  logic [TERM_W-1:0] s1_k_r;
  logic              s1_last_r;
  // output register
  logic              o_v_r, o_v_nxt;
  val_t              o_val_r, o_val_nxt;
  logic              o_sat_r, o_sat_nxt;
  logic [TERM_W-1:0] o_k_r;
  logic              o_last_r;
  rs_t               rxy;
  rs_t               rz;

  assign advance = !o_v_r || out_ch.ready;

  always_comb begin
    rxy = mul_rs(req.vx, req.vy);
    s1_v_nxt = req.valid;
    s1_a_nxt = VAL_MAX;
    s1_as_nxt = 1'b0;
    s1_ah_nxt = 1'b1;
    if (req.hx && req.hy) begin
      s1_a_nxt = rxy.val;
      s1_as_nxt = req.sx | req.sy | rxy.sat;
    end else if (req.hx) begin
      s1_a_nxt = req.vx;
      s1_as_nxt = req.sx;
    end else if (req.hy) begin
      s1_a_nxt = req.vy;
      s1_as_nxt = req.sy;
    end else begin
      s1_ah_nxt = 1'b0;
    end
  end

  always_comb begin
    rz = mul_rs(s1_a_r, s1_vz_r);
    o_v_nxt = s1_v_r;
    if (s1_hz_r && s1_ah_r) begin
      o_val_nxt = rz.val;
      o_sat_nxt = s1_as_r | s1_sz_r | rz.sat;
    end else if (s1_hz_r) begin
      o_val_nxt = s1_vz_r;
      o_sat_nxt = s1_sz_r;
    end else if (s1_ah_r) begin
      o_val_nxt = s1_a_r;
      o_sat_nxt = s1_as_r;
    end else begin
      // constant term: 1.0 clips to the largest code
      o_val_nxt = VAL_MAX;
      o_sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= s1_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_a_r <= s1_a_nxt;
      s1_as_r <= s1_as_nxt;
      s1_ah_r <= s1_ah_nxt;
      s1_hz_r <= req.hz;
      s1_vz_r <= req.vz;
      s1_sz_r <= req.sz;
      s1_k_r <= req.k;
      s1_last_r <= req.last;
      o_val_r <= o_val_nxt;
      o_sat_r <= o_sat_nxt;
      o_k_r <= s1_k_r;
      o_last_r <= s1_last_r;
    end
  end

  assign out_ch.valid = o_v_r;
  assign out_ch.term_value = o_val_r;
  assign out_ch.term_index = o_k_r;
  assign out_ch.last_term = o_last_r;
  assign out_ch.saturated = o_sat_r;

endmodule
